// ----- rtl/kla_pkg.sv -----
// ----------------------------------------------------------------------------
// kla_pkg
// Shared types, codes and defaults of the kth-ancestor engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kla_pkg;

  // default sizes
  localparam int N_NODES_DEF = 1024;
  localparam int LEVELS_DEF  = 10;

  // field widths
  localparam int NODE_W  = 10;
  localparam int WORD_W  = 11;
  localparam int STEPS_W = 10;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef logic [NODE_W-1:0]         node_t;
  typedef logic [WORD_W-1:0]         word_t;   // raw table entry / node count
  typedef logic signed [WORD_W-1:0]  sword_t;  // signed node reference
  typedef logic [STEPS_W-1:0]        steps_t;

  // item kind codes
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // "no node" marker, -1 in 11 bits
  localparam word_t NO_NODE = '1;

  // register map
  localparam logic  REG_NODE_COUNT = 1'b0;
  localparam word_t NODE_COUNT_RST = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B_RD,
    ST_B_CHK,
    ST_B_WR,
    ST_Q_STEP,
    ST_Q_WAIT
  } ctrl_state_t;

endpackage

// ----- rtl/kla_in_if.sv -----
// ----------------------------------------------------------------------------
// kla_in_if
// Input item channel: load or query transaction with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kla_in_if;
  import kla_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  node_t  node;
  sword_t parent;
  logic   last_load;
  steps_t steps;

  modport source (output valid, kind, node, parent, last_load, steps, input ready);
  modport sink   (input valid, kind, node, parent, last_load, steps, output ready);
endinterface

// ----- rtl/kla_out_if.sv -----
// ----------------------------------------------------------------------------
// kla_out_if
// Result channel: one ancestor per query transaction, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kla_out_if;
  import kla_pkg::*;

  logic   valid;
  logic   ready;
  sword_t ancestor;

  modport source (output valid, ancestor, input ready);
  modport sink   (input valid, ancestor, output ready);
endinterface

// ----- rtl/kla_table.sv -----
// ----------------------------------------------------------------------------
// kla_table
// Jump table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kla_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  kla_pkg::word_t  wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output kla_pkg::word_t  rdata
);
  import kla_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/kla_cfg.sv -----
// ----------------------------------------------------------------------------
// kla_cfg
// APB register block: holds node_count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kla_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kla_pkg::PADDR_W-1:0]   paddr,
  input  logic [kla_pkg::PDATA_W-1:0]   pwdata,
  output logic [kla_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output kla_pkg::word_t                node_count
);
  import kla_pkg::*;

  logic reg_idx;
  logic wr;

  assign reg_idx = paddr[PADDR_W-1];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (wr && (reg_idx == REG_NODE_COUNT)) begin
      node_count <= pwdata[WORD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_NODE_COUNT) begin
      prdata = {{(PDATA_W-WORD_W){1'b0}}, node_count};
    end
  end

endmodule

// ----- rtl/kla_ctrl.sv -----
// ----------------------------------------------------------------------------
// kla_ctrl
// Sequencer: level-0 loads, table build sweep, query walk, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kla_ctrl #(
  parameter int N_NODES = kla_pkg::N_NODES_DEF,
  parameter int LEVELS  = kla_pkg::LEVELS_DEF,
  parameter int NW      = 10,
  parameter int LW      = 4,
  parameter int AW      = 14
) (
  input  logic            clk,
  input  logic            rst,
  kla_in_if.sink          item,
  kla_out_if.source       result,
  input  kla_pkg::word_t  node_count,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output kla_pkg::word_t  mem_wdata,
  output logic            mem_re,
  output logic [AW-1:0]   mem_raddr,
  input  kla_pkg::word_t  mem_rdata
);
  import kla_pkg::*;

  localparam int LCW = $clog2(LEVELS + 1);

  ctrl_state_t       state, state_next;
  logic [LCW-1:0]    lvl;
  word_t             idx;
  word_t             cur;
  steps_t            steps_r;
  logic              built;
  logic              out_valid;
  word_t             out_data;

  word_t             cnt;
  logic              acc;
  logic              cur_ok;
  logic              p_ok;
  logic              idx_last;
  logic              lvl_last;
  logic              lvl_over;
  logic              build_go;

  // nodes in use, clamped to table size
  assign cnt = (32'(node_count) < N_NODES) ? node_count : WORD_W'(N_NODES);

  // input taken only when idle and the result register is free or draining
  assign item.ready = (state == ST_IDLE) && (!out_valid || result.ready);

  assign acc      = item.valid && item.ready;
  assign cur_ok   = !cur[WORD_W-1] && (cur < cnt);
  assign p_ok     = !mem_rdata[WORD_W-1] && (mem_rdata < cnt);
  assign idx_last = (idx + 11'd1) == cnt;
  assign lvl_last = lvl == LCW'(LEVELS - 1);
  assign lvl_over = lvl == LCW'(LEVELS);
  assign build_go = (cnt != '0) && (LEVELS > 1);

  assign result.valid    = out_valid;
  assign result.ancestor = $signed(out_data);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (item.kind == KIND_LOAD) begin
            if (item.last_load && build_go) state_next = ST_B_RD;
          end else if (built && (item.steps != '0)) begin
            state_next = ST_Q_STEP;
          end
        end
      end
      ST_B_RD:  state_next = ST_B_CHK;
      ST_B_CHK: begin
        if (p_ok) begin
          state_next = ST_B_WR;
        end else if (idx_last && lvl_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_B_RD;
        end
      end
      ST_B_WR: begin
        if (idx_last && lvl_last) state_next = ST_IDLE;
        else                      state_next = ST_B_RD;
      end
      ST_Q_STEP: begin
        if ((steps_r == '0) || !cur_ok || lvl_over) state_next = ST_IDLE;
        else if (steps_r[0])                         state_next = ST_Q_WAIT;
      end
      ST_Q_WAIT: state_next = ST_Q_STEP;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory ports
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = NO_NODE;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    case (state)
      ST_IDLE: begin
        if (acc && (item.kind == KIND_LOAD) && (32'(item.node) < N_NODES)) begin
          mem_we    = 1'b1;
          mem_waddr = {LW'(0), NW'(item.node)};
          mem_wdata = item.parent[WORD_W-1] ? NO_NODE : $unsigned(item.parent);
        end
      end
      ST_B_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {LW'(lvl - 1'b1), NW'(idx)};
      end
      ST_B_CHK: begin
        if (p_ok) begin
          mem_re    = 1'b1;
          mem_raddr = {LW'(lvl - 1'b1), NW'(mem_rdata)};
        end else begin
          mem_we    = 1'b1;
          mem_waddr = {LW'(lvl), NW'(idx)};
          mem_wdata = NO_NODE;
        end
      end
      ST_B_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {LW'(lvl), NW'(idx)};
        mem_wdata = mem_rdata;
      end
      ST_Q_STEP: begin
        if ((steps_r != '0) && cur_ok && !lvl_over && steps_r[0]) begin
          mem_re    = 1'b1;
          mem_raddr = {LW'(lvl), NW'(cur)};
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      built     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && result.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (item.kind == KIND_LOAD) begin
              built <= item.last_load && !build_go;
            end else if (!built || (item.steps == '0)) begin
              out_valid <= 1'b1;
            end
          end
        end
        ST_B_CHK, ST_B_WR: begin
          if (((state == ST_B_WR) || !p_ok) && idx_last && lvl_last) built <= 1'b1;
        end
        ST_Q_STEP: begin
          if ((steps_r == '0) || !cur_ok || lvl_over) out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (item.kind == KIND_LOAD) begin
            lvl <= LCW'(1);
            idx <= '0;
          end else begin
            out_data <= built ? {1'b0, item.node} : NO_NODE;
            cur      <= {1'b0, item.node};
            steps_r  <= item.steps;
            lvl      <= '0;
          end
        end
      end
      ST_B_CHK, ST_B_WR: begin
        if ((state == ST_B_WR) || !p_ok) begin
          if (idx_last) begin
            idx <= '0;
            lvl <= lvl + 1'b1;
          end else begin
            idx <= idx + 11'd1;
          end
        end
      end
      ST_Q_STEP: begin
        if (steps_r == '0) begin
          out_data <= cur_ok ? cur : NO_NODE;
        end else if (!cur_ok || lvl_over) begin
          out_data <= NO_NODE;
        end else if (!steps_r[0]) begin
          steps_r <= steps_r >> 1;
          lvl     <= lvl + 1'b1;
        end
      end
      ST_Q_WAIT: begin
        cur     <= mem_rdata;
        steps_r <= steps_r >> 1;
        lvl     <= lvl + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/kth_ancestor_binary_lifting.sv -----
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting
// Kth-ancestor engine for a rooted tree by binary lifting. Load transactions
// write a node's parent into level 0 of the jump table; the load flagged
// last_load sweeps levels 1..LEVELS-1 over nodes 0..node_count-1 (clamped to
// N_NODES), reading, checking and writing each entry in turn, and no
// transaction is accepted during the sweep. A query transaction walks the
// set bits of steps through the table: each bit position is visited in turn,
// from the lowest up, and each set bit adds a table read that moves the walk
// on to that ancestor; a query before the build completes or with zero steps
// is answered from the accept, with no walk. The pace is set by the single
// read port of the jump table memory and its registered read data, every
// lookup depending on the one before it. One item is in flight at a time; a
// result sits in an output register, and a new transaction is taken while
// that register is empty or being drained. Unknown ancestors and walks past
// the root return -1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kth_ancestor_binary_lifting #(
  parameter int N_NODES = kla_pkg::N_NODES_DEF,
  parameter int LEVELS  = kla_pkg::LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  kla_in_if.sink                        item,
  kla_out_if.source                     result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kla_pkg::PADDR_W-1:0]   paddr,
  input  logic [kla_pkg::PDATA_W-1:0]   pwdata,
  output logic [kla_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import kla_pkg::*;

  // table address is {level, node}
  localparam int NW    = $clog2(N_NODES);
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW    = LW + NW;
  localparam int DEPTH = LEVELS * (2 ** NW);

  word_t          node_count;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  word_t          mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  word_t          mem_rdata;

  kla_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_count (node_count)
  );

  // jump table: LEVELS rows of 2**NW entries
  kla_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer: loads, build sweep, query walk
  kla_ctrl #(
    .N_NODES (N_NODES),
    .LEVELS  (LEVELS),
    .NW      (NW),
    .LW      (LW),
    .AW      (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .result     (result),
    .node_count (node_count),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

endmodule
